>>> rtl/mkfm_pkg.sv
// Package for the multi-keyword first-match unit.
// Holds default sizes, field widths, status codes, function codes, the controller interface and case folding.
// Has no dependencies.
package mkfm_pkg;

   localparam int KEYWORD_SLOTS_DEF   = 32;
   localparam int KEYWORD_MAX_LEN_DEF = 32;
   localparam int TEXT_MAX_LEN_DEF    = 1024;

   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 10;
   localparam int IDX_W    = 5;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 24;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_KW_LONG   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TEXT_LONG = 3'd4;

   localparam logic FUNC_KEYWORD = 1'b0;
   localparam logic FUNC_TEXT    = 1'b1;

   typedef struct packed {
      logic accept;
      logic init;
      logic next_pos;
      logic first_kw;
      logic next_kw;
      logic first_chr;
      logic read;
      logic next_chr;
      logic hit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic text_go;
      logic pos_end;
      logic kw_end;
      logic fits;
      logic chr_eq;
      logic chr_last;
   } stat_type;

   function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

>>> rtl/mkfm_ctrl.sv
// Controller of the multi-keyword first-match unit: input handshake and search sequencing.
// Depends on mkfm_pkg.
module mkfm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mkfm_pkg::stat_type  stat,
   output mkfm_pkg::cmd_type   cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_POS  = 6'b000010,
      S_KW   = 6'b000100,
      S_READ = 6'b001000,
      S_CMP  = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = stat.out_free;
            cmd.accept = req_tvalid && stat.out_free;
            if (cmd.accept && stat.text_go) begin
               cmd.init = 1'b1;
               state_in = S_POS;
            end
         end
         S_POS: begin
            if (stat.pos_end) begin
               state_in = S_EMIT;
            end else begin
               cmd.first_kw = 1'b1;
               state_in     = S_KW;
            end
         end
         S_KW: begin
            if (stat.kw_end) begin
               cmd.next_pos = 1'b1;
               state_in     = S_POS;
            end else if (!stat.fits) begin
               cmd.next_kw = 1'b1;
            end else begin
               cmd.first_chr = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!stat.chr_eq) begin
               cmd.next_kw = 1'b1;
               state_in    = S_KW;
            end else if (stat.chr_last) begin
               cmd.hit  = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.next_chr = 1'b1;
               state_in     = S_READ;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/mkfm_dp.sv
// Datapath of the multi-keyword first-match unit: keyword and text memories, counters,
// byte compare and the result register. Depends on mkfm_pkg.
module mkfm_dp #(
   parameter int KEYWORD_SLOTS   = mkfm_pkg::KEYWORD_SLOTS_DEF,
   parameter int KEYWORD_MAX_LEN = mkfm_pkg::KEYWORD_MAX_LEN_DEF,
   parameter int TEXT_MAX_LEN    = mkfm_pkg::TEXT_MAX_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tuser,
   input  logic [mkfm_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        rsp_tuser,
   output logic [mkfm_pkg::RSP_W-1:0]  rsp_tdata,
   input  mkfm_pkg::cmd_type           cmd,
   output mkfm_pkg::stat_type          stat
);

   localparam int KwDepth = KEYWORD_SLOTS * KEYWORD_MAX_LEN;
   localparam int KwAw    = (KwDepth > 1) ? $clog2(KwDepth) : 1;
   localparam int TAw     = $clog2(TEXT_MAX_LEN);
   localparam int KW      = $clog2(KEYWORD_SLOTS);
   localparam int LW      = $clog2(KEYWORD_MAX_LEN + 1);
   localparam int TLW     = $clog2(TEXT_MAX_LEN + 1);

   logic [mkfm_pkg::CHAR_W-1:0] kw_mem [KwDepth];
   logic [mkfm_pkg::CHAR_W-1:0] text_mem [TEXT_MAX_LEN];
   logic [LW-1:0]               len_ff [KEYWORD_SLOTS];
   logic                        flag_ff [KEYWORD_SLOTS];

   logic [KW-1:0]  stored_ff, stored_in;
   logic [LW-1:0]  plen_ff, plen_in;
   logic           povf_ff, povf_in;
   logic [TLW-1:0] tlen_ff, tlen_in;
   logic           tovf_ff, tovf_in;
   logic [TLW-1:0] p_ff, p_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [LW-1:0]  i_ff, i_in;
   logic           hit_ff, hit_in;
   logic [mkfm_pkg::CHAR_W-1:0] tq_ff, kq_ff;

   logic                         rv_ff, rv_in;
   logic                         rk_ff, rk_in;
   logic [mkfm_pkg::STATUS_W-1:0] rs_ff, rs_in;
   logic                         rf_ff, rf_in;
   logic [mkfm_pkg::POS_W-1:0]   rp_ff, rp_in;
   logic [mkfm_pkg::IDX_W-1:0]   ri_ff, ri_in;
   logic [mkfm_pkg::IDX_W-1:0]   rc_ff, rc_in;

   logic                         func;
   logic [mkfm_pkg::CHAR_W-1:0]  chr;
   logic                         exact;
   logic                         zero;
   logic [mkfm_pkg::STATUS_W-1:0] kst;
   logic                         kw_wr, tx_wr, len_wr;
   logic [KwAw-1:0]              kw_waddr, kw_raddr;
   logic [TAw-1:0]               tx_raddr;
   logic [TLW:0]                 end_pos;
   logic [mkfm_pkg::CHAR_W-1:0]  a, b;

   assign func  = req_tuser;
   assign chr   = req_tdata[7:0];
   assign exact = req_tdata[8];
   assign zero  = (chr == '0);

   assign kw_waddr = KwAw'(KwAw'(stored_ff) * KwAw'(KEYWORD_MAX_LEN) + KwAw'(plen_ff));
   assign kw_raddr = KwAw'(KwAw'(k_ff) * KwAw'(KEYWORD_MAX_LEN) + KwAw'(i_ff));
   assign tx_raddr = TAw'(p_ff + TLW'(i_ff));
   assign end_pos  = (TLW + 1)'(p_ff) + (TLW + 1)'(len_ff[k_ff]);

   assign kw_wr  = cmd.accept && func == mkfm_pkg::FUNC_KEYWORD && !zero
                   && plen_ff < LW'(KEYWORD_MAX_LEN);
   assign tx_wr  = cmd.accept && func == mkfm_pkg::FUNC_TEXT && !zero
                   && tlen_ff < TLW'(TEXT_MAX_LEN);

   always_comb begin
      if (plen_ff == '0 && !povf_ff) begin
         kst = mkfm_pkg::ST_EMPTY;
      end else if (stored_ff >= KW'(KEYWORD_SLOTS - 1)) begin
         kst = mkfm_pkg::ST_FULL;
      end else if (povf_ff) begin
         kst = mkfm_pkg::ST_KW_LONG;
      end else begin
         kst = mkfm_pkg::ST_OK;
      end
   end

   assign len_wr = cmd.accept && func == mkfm_pkg::FUNC_KEYWORD && zero
                   && kst == mkfm_pkg::ST_OK;

   always_ff @(posedge clock) begin
      if (kw_wr) begin
         kw_mem[kw_waddr] <= chr;
      end
      if (cmd.read) begin
         kq_ff <= kw_mem[kw_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tx_wr) begin
         text_mem[TAw'(tlen_ff)] <= chr;
      end
      if (cmd.read) begin
         tq_ff <= text_mem[tx_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_wr) begin
         len_ff[stored_ff]  <= plen_ff;
         flag_ff[stored_ff] <= exact;
      end
   end

   assign a = flag_ff[k_ff] ? tq_ff : mkfm_pkg::fold(tq_ff);
   assign b = flag_ff[k_ff] ? kq_ff : mkfm_pkg::fold(kq_ff);

   assign stat.out_free = !rv_ff || rsp_tready;
   assign stat.text_go  = func == mkfm_pkg::FUNC_TEXT && zero && !tovf_ff;
   assign stat.pos_end  = (p_ff == tlen_ff);
   assign stat.kw_end   = (k_ff == stored_ff);
   assign stat.fits     = end_pos <= (TLW + 1)'(tlen_ff);
   assign stat.chr_eq   = (a == b);
   assign stat.chr_last = (LW'(i_ff + LW'(1)) == len_ff[k_ff]);

   always_comb begin
      stored_in = stored_ff;
      plen_in   = plen_ff;
      povf_in   = povf_ff;
      tlen_in   = tlen_ff;
      tovf_in   = tovf_ff;
      p_in      = p_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      hit_in    = hit_ff;
      rv_in     = rv_ff && !rsp_tready;
      rk_in     = rk_ff;
      rs_in     = rs_ff;
      rf_in     = rf_ff;
      rp_in     = rp_ff;
      ri_in     = ri_ff;
      rc_in     = rc_ff;
      if (cmd.accept) begin
         if (func == mkfm_pkg::FUNC_KEYWORD) begin
            if (!zero) begin
               if (kw_wr) begin
                  plen_in = plen_ff + LW'(1);
               end else begin
                  povf_in = 1'b1;
               end
            end else begin
               plen_in = '0;
               povf_in = 1'b0;
               if (len_wr) begin
                  stored_in = stored_ff + KW'(1);
               end
               rv_in = 1'b1;
               rk_in = mkfm_pkg::FUNC_KEYWORD;
               rs_in = kst;
               rf_in = 1'b0;
               rp_in = '0;
               ri_in = len_wr ? mkfm_pkg::IDX_W'(stored_ff) : '0;
               rc_in = mkfm_pkg::IDX_W'(stored_in);
            end
         end else begin
            if (!zero) begin
               if (tx_wr) begin
                  tlen_in = tlen_ff + TLW'(1);
               end else begin
                  tovf_in = 1'b1;
               end
            end else if (tovf_ff) begin
               tlen_in = '0;
               tovf_in = 1'b0;
               rv_in   = 1'b1;
               rk_in   = mkfm_pkg::FUNC_TEXT;
               rs_in   = mkfm_pkg::ST_TEXT_LONG;
               rf_in   = 1'b0;
               rp_in   = '0;
               ri_in   = '0;
               rc_in   = mkfm_pkg::IDX_W'(stored_ff);
            end
         end
      end
      if (cmd.init) begin
         p_in   = '0;
         hit_in = 1'b0;
      end
      if (cmd.next_pos) begin
         p_in = p_ff + TLW'(1);
      end
      if (cmd.first_kw) begin
         k_in = '0;
      end
      if (cmd.next_kw) begin
         k_in = k_ff + KW'(1);
      end
      if (cmd.first_chr) begin
         i_in = '0;
      end
      if (cmd.next_chr) begin
         i_in = i_ff + LW'(1);
      end
      if (cmd.hit) begin
         hit_in = 1'b1;
      end
      if (cmd.emit) begin
         tlen_in = '0;
         tovf_in = 1'b0;
         rv_in   = 1'b1;
         rk_in   = mkfm_pkg::FUNC_TEXT;
         rs_in   = mkfm_pkg::ST_OK;
         rf_in   = hit_ff;
         rp_in   = hit_ff ? mkfm_pkg::POS_W'(p_ff) : '0;
         ri_in   = hit_ff ? mkfm_pkg::IDX_W'(k_ff) : '0;
         rc_in   = mkfm_pkg::IDX_W'(stored_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         plen_ff   <= '0;
         povf_ff   <= 1'b0;
         tlen_ff   <= '0;
         tovf_ff   <= 1'b0;
         rv_ff     <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         stored_ff <= stored_in;
         plen_ff   <= plen_in;
         povf_ff   <= povf_in;
         tlen_ff   <= tlen_in;
         tovf_ff   <= tovf_in;
         rv_ff     <= rv_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      k_ff  <= k_in;
      i_ff  <= i_in;
      rk_ff <= rk_in;
      rs_ff <= rs_in;
      rf_ff <= rf_in;
      rp_ff <= rp_in;
      ri_ff <= ri_in;
      rc_ff <= rc_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rk_ff;
   assign rsp_tdata  = {rc_ff, ri_ff, rp_ff, rf_ff, rs_ff};

endmodule

>>> rtl/multi_keyword_first_match_unit.sv
// Top level of the multi-keyword first-match unit.
// Instantiates mkfm_ctrl and mkfm_dp; depends on mkfm_pkg.
//
// Channel   Direction  tuser         tdata
// req_      in         func          char_code, exact_case
// rsp_      out        reply_kind    status, found, match_position, keyword_index, keyword_count
//
// Keyword bytes and text bytes are taken one per cycle while no search runs and the result register is free.
// A text terminator starts a search unless the text overflowed: positions are visited in turn,
// at each one every keyword that fits is tried, and each of its bytes is read, then compared.
// The reply then goes to the result register, waiting while that register is still full.
// The result register holds a reply until taken; a new item is taken in the same cycle.
// Reset is synchronous and active high and empties both buffers and the keyword table.
module multi_keyword_first_match_unit #(
   parameter int KEYWORD_SLOTS   = mkfm_pkg::KEYWORD_SLOTS_DEF,
   parameter int KEYWORD_MAX_LEN = mkfm_pkg::KEYWORD_MAX_LEN_DEF,
   parameter int TEXT_MAX_LEN    = mkfm_pkg::TEXT_MAX_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_tuser,  // func
   input  logic [mkfm_pkg::REQ_W-1:0]  req_tdata,  // char_code, exact_case
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        rsp_tuser,  // reply_kind
   // status, found, match_position, keyword_index, keyword_count
   output logic [mkfm_pkg::RSP_W-1:0]  rsp_tdata
);

   mkfm_pkg::cmd_type  cmd;
   mkfm_pkg::stat_type stat;

   mkfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mkfm_dp #(
      .KEYWORD_SLOTS   (KEYWORD_SLOTS),
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .TEXT_MAX_LEN    (TEXT_MAX_LEN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
